// ===== rtl/cdrc_pkg.sv =====
package cdrc_pkg;

   // Widths of the datapath and of the table packing.
   localparam int RATE_W            = 32;
   localparam int CNT_W             = 5;
   localparam int FIELD_W           = 16;
   localparam int FIELD_WIDTH_W     = 5;
   localparam int SHIFT_W           = 5;
   localparam int TAB_SLOTS         = 8;
   localparam int TAB_IDX_W         = 3;
   localparam int TAB_DIV_W         = 16;
   localparam int TAB_VAL_W         = 8;
   localparam int UP_W              = 31;
   localparam int CSR_IDX_W         = 3;
   localparam int CSR_DATA_W        = 64;
   localparam int PAIRS             = 4;

   // Defaults for the top-level parameters.
   localparam int TABLE_ENTRIES_DEF = 8;
   localparam int RATE_BITS_DEF     = 32;

   // Largest field width that is honored, and the power-of-two exponent cap.
   localparam logic [FIELD_WIDTH_W-1:0] MAX_FIELD_WIDTH = 5'd16;
   localparam logic [SHIFT_W-1:0]       POW2_CAP        = 5'd31;
   localparam logic [UP_W-1:0]          UP_LIMIT        = '1;

   typedef enum logic [2:0] {
      OP_RECALC  = 3'd0,
      OP_ROUND   = 3'd1,
      OP_SET     = 3'd2,
      OP_SAVE    = 3'd3,
      OP_RESTORE = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_LINEAR    = 2'd0,
      MODE_ONE_BASED = 2'd1,
      MODE_POW2      = 2'd2,
      MODE_TABLE     = 2'd3
   } div_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIV_MODE    = 3'd0,
      CSR_FIELD_SHIFT = 3'd1,
      CSR_FIELD_WIDTH = 3'd2,
      CSR_HIWORD_MASK = 3'd3,
      CSR_TABLE_0     = 3'd4,
      CSR_TABLE_1     = 3'd5,
      CSR_TABLE_2     = 3'd6,
      CSR_TABLE_3     = 3'd7
   } csr_idx_type;

   // Divider status: ceiling quotient and lowest set bit of that quotient.
   typedef struct packed {
      logic                done;
      logic [RATE_W-1:0]   quot;
      logic [CNT_W-1:0]    low_bit;
   } div_res_type;

   // Table scan results; lookup misses read as zero, and no divisor at or above the key reads as all ones.
   typedef struct packed {
      logic                 done;
      logic [TAB_DIV_W-1:0] val_div;
      logic [TAB_DIV_W-1:0] max_div;
      logic [UP_W-1:0]      min_ge;
      logic [TAB_VAL_W-1:0] div_val;
   } scan_res_type;

   // Two to the power e, with the exponent saturated at 31.
   function automatic logic [RATE_W-1:0] pow2_sat(input logic [FIELD_W-1:0] e);
      logic [SHIFT_W-1:0] sh;
      sh = (e > {{(FIELD_W-SHIFT_W){1'b0}}, POW2_CAP}) ? POW2_CAP : e[SHIFT_W-1:0];
      return {{(RATE_W-1){1'b0}}, 1'b1} << sh;
   endfunction

   // Clamp a divisor to the range one to mx.
   function automatic logic [RATE_W-1:0] clamp_div(input logic [RATE_W-1:0] d,
                                                   input logic [RATE_W-1:0] mx);
      logic [RATE_W-1:0] c;
      c = (d > mx) ? mx : d;
      if (c == '0) begin
         c = {{(RATE_W-1){1'b0}}, 1'b1};
      end
      return c;
   endfunction

endpackage

// ===== rtl/clock_divider_rate_calc.sv =====
// From an accepted start to the result strobe: save, restore, unused opcodes and a set with
// a zero rate finish straight from idle; recalc and set run one division (none for a recalc
// with a zero divisor), round two, plus one table walk each in table mode.
// One item at a time, set by the shared 32-step restoring divider; the next start is taken
// in the strobe cycle. The receiver cannot stall. Synchronous reset restores the register
// defaults and clears the divider register and the saved field.
module clock_divider_rate_calc #(
   parameter int TABLE_ENTRIES = cdrc_pkg::TABLE_ENTRIES_DEF,
   parameter int RATE_BITS     = cdrc_pkg::RATE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [2:0]                         req_opcode,
   input  logic [cdrc_pkg::RATE_W-1:0]        req_parent_rate,
   input  logic [cdrc_pkg::RATE_W-1:0]        req_requested_rate,
   output logic                               rsp_strobe,
   output logic [cdrc_pkg::RATE_W-1:0]        rsp_result_rate,
   output logic [cdrc_pkg::RATE_W-1:0]        rsp_divisor,
   output logic [cdrc_pkg::RATE_W-1:0]        rsp_register_value,
   output logic                               rsp_bad_request,
   output logic                               rsp_zero_divisor,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cdrc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cdrc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int W   = cdrc_pkg::RATE_W;
   localparam int FW  = cdrc_pkg::FIELD_W;
   localparam int SW  = cdrc_pkg::SHIFT_W;
   localparam int WW  = cdrc_pkg::FIELD_WIDTH_W;
   localparam int DW  = cdrc_pkg::TAB_DIV_W;
   localparam int CW  = cdrc_pkg::CNT_W;
   localparam int NP  = cdrc_pkg::PAIRS;
   localparam int NS  = cdrc_pkg::TAB_SLOTS;
   localparam int TAB_USED = (TABLE_ENTRIES > NS) ? NS : TABLE_ENTRIES;
   localparam logic [W-1:0] RATE_MASK =
      (RATE_BITS >= W) ? '1 : W'((64'd1 << RATE_BITS) - 64'd1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DIV  = 3'b100
   } state_type;

   // Configuration registers.
   cdrc_pkg::div_mode_type         mode_ff, mode_in;
   logic [SW-1:0]                  shift_ff, shift_in;
   logic [WW-1:0]                  width_ff, width_in;
   logic                           hiword_ff, hiword_in;
   logic [NP-1:0][2*W-1:0]         pair_ff, pair_in;

   // Architectural state and item context.
   logic [W-1:0]                   divr_ff, divr_in;
   logic [FW-1:0]                  saved_ff, saved_in;
   state_type                      state_ff, state_in;
   cdrc_pkg::opcode_type           op_ff, op_in;
   logic [W-1:0]                   prate_ff, prate_in;
   logic [W-1:0]                   dv_ff, dv_in;
   logic                           second_ff, second_in;

   // Result registers.
   logic                           strobe_ff, strobe_in;
   logic [W-1:0]                   res_rate_ff, res_rate_in;
   logic [W-1:0]                   res_div_ff, res_div_in;
   logic                           res_bad_ff, res_bad_in;
   logic                           res_zero_ff, res_zero_in;

   // Field decode and helper values.
   cdrc_pkg::opcode_type           req_op;
   logic [W-1:0]                   in_prate, in_rate, cur_prate;
   logic [WW-1:0]                  w_eff;
   logic [FW:0]                    mask_ext;
   logic [FW-1:0]                  m;
   logic [W-1:0]                   fm;
   logic [FW-1:0]                  fv;
   logic [W-1:0]                   dec_fixed, rec_dv, mx, rnd_d, rnd_dc;
   logic [W-1:0]                   enc_v;
   logic [FW-1:0]                  set_v;
   logic [W-1:0]                   set_reg, rst_reg;
   logic [NS-1:0][W-1:0]           tab_entries;

   // Sequencer handshakes with the divider and the table walker.
   logic                           div_go, scan_go;
   logic [W-1:0]                   div_a, div_b;
   cdrc_pkg::div_res_type          div_res;
   cdrc_pkg::scan_res_type         scan_res;
   logic                           rec_go, rnd_go, set_fin, fin;
   logic [W-1:0]                   fin_rate, fin_div;
   logic                           fin_bad, fin_zero;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign req_op    = cdrc_pkg::opcode_type'(req_opcode);
   assign in_prate  = req_parent_rate & RATE_MASK;
   assign in_rate   = req_requested_rate & RATE_MASK;
   assign cur_prate = (state_ff == S_IDLE) ? in_prate : prate_ff;

   // Table entries beyond the configured count read as empty.
   for (genvar g = 0; g < NS; g++) begin : g_tab
      assign tab_entries[g] = (g < TABLE_ENTRIES) ? pair_ff[g/2][(g%2)*W +: W] : '0;
   end

   // Field mask, its position in the register and the current field value.
   always_comb begin
      w_eff    = (width_ff > cdrc_pkg::MAX_FIELD_WIDTH) ? cdrc_pkg::MAX_FIELD_WIDTH : width_ff;
      mask_ext = ({{FW{1'b0}}, 1'b1} << w_eff) - {{FW{1'b0}}, 1'b1};
      m        = mask_ext[FW-1:0];
      fm       = {{(W-FW){1'b0}}, m} << shift_ff;
      fv       = FW'(divr_ff >> shift_ff) & m;
   end

   // Divisor decode and the largest allowed divisor for each mode.
   always_comb begin
      case (mode_ff)
         cdrc_pkg::MODE_LINEAR: begin
            dec_fixed = {{(W-FW-1){1'b0}}, {1'b0, fv} + {{FW{1'b0}}, 1'b1}};
            mx        = {{(W-FW-1){1'b0}}, {1'b0, m} + {{FW{1'b0}}, 1'b1}};
         end
         cdrc_pkg::MODE_ONE_BASED: begin
            dec_fixed = {{(W-FW){1'b0}}, fv};
            mx        = {{(W-FW){1'b0}}, m};
         end
         cdrc_pkg::MODE_POW2: begin
            dec_fixed = cdrc_pkg::pow2_sat(fv);
            mx        = cdrc_pkg::pow2_sat(m);
         end
         default: begin
            dec_fixed = '0;
            mx        = {{(W-DW){1'b0}}, scan_res.max_div};
         end
      endcase
      rec_dv = (mode_ff == cdrc_pkg::MODE_TABLE) ? {{(W-DW){1'b0}}, scan_res.val_div}
                                                 : dec_fixed;
      rnd_d  = (mode_ff == cdrc_pkg::MODE_TABLE) ? {1'b0, scan_res.min_ge} : div_res.quot;
      rnd_dc = cdrc_pkg::clamp_div(rnd_d, mx);
   end

   // Field encode for set, saturated to the mask, and the register images for set and restore.
   always_comb begin
      case (mode_ff)
         cdrc_pkg::MODE_LINEAR:    enc_v = div_res.quot - {{(W-1){1'b0}}, 1'b1};
         cdrc_pkg::MODE_ONE_BASED: enc_v = div_res.quot;
         cdrc_pkg::MODE_POW2:      enc_v = {{(W-CW){1'b0}}, div_res.low_bit};
         default:                  enc_v = {{(W-cdrc_pkg::TAB_VAL_W){1'b0}}, scan_res.div_val};
      endcase
      set_v   = (enc_v > {{(W-FW){1'b0}}, m}) ? m : enc_v[FW-1:0];
      set_reg = (hiword_ff ? {fm[FW-1:0], {FW{1'b0}}} : (divr_ff & ~fm)) |
                ({{(W-FW){1'b0}}, set_v} << shift_ff);
      rst_reg = (divr_ff & ~fm) | ({{(W-FW){1'b0}}, saved_ff} << shift_ff);
   end

   // Configuration writes.
   always_comb begin
      mode_in   = mode_ff;
      shift_in  = shift_ff;
      width_in  = width_ff;
      hiword_in = hiword_ff;
      pair_in   = pair_ff;
      if (csr_valid && csr_ready) begin
         case (cdrc_pkg::csr_idx_type'(csr_index))
            cdrc_pkg::CSR_DIV_MODE:    mode_in   = cdrc_pkg::div_mode_type'(csr_wdata[1:0]);
            cdrc_pkg::CSR_FIELD_SHIFT: shift_in  = csr_wdata[SW-1:0];
            cdrc_pkg::CSR_FIELD_WIDTH: width_in  = csr_wdata[WW-1:0];
            cdrc_pkg::CSR_HIWORD_MASK: hiword_in = csr_wdata[0];
            cdrc_pkg::CSR_TABLE_0:     pair_in[0] = csr_wdata;
            cdrc_pkg::CSR_TABLE_1:     pair_in[1] = csr_wdata;
            cdrc_pkg::CSR_TABLE_2:     pair_in[2] = csr_wdata;
            cdrc_pkg::CSR_TABLE_3:     pair_in[3] = csr_wdata;
            default: begin
               pair_in = pair_ff;
            end
         endcase
      end
   end

   // Operation sequencer: accept, divide, walk the table, and finish.
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      prate_in    = prate_ff;
      dv_in       = dv_ff;
      second_in   = second_ff;
      divr_in     = divr_ff;
      saved_in    = saved_ff;
      strobe_in   = 1'b0;
      res_rate_in = res_rate_ff;
      res_div_in  = res_div_ff;
      res_bad_in  = res_bad_ff;
      res_zero_in = res_zero_ff;
      div_go      = 1'b0;
      div_a       = prate_ff;
      div_b       = dv_ff;
      scan_go     = 1'b0;
      rec_go      = 1'b0;
      rnd_go      = 1'b0;
      set_fin     = 1'b0;
      fin         = 1'b0;
      fin_rate    = '0;
      fin_div     = '0;
      fin_bad     = 1'b0;
      fin_zero    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req_op;
               prate_in  = in_prate;
               second_in = 1'b0;
               case (req_op)
                  cdrc_pkg::OP_RECALC: begin
                     if (mode_ff == cdrc_pkg::MODE_TABLE) begin
                        scan_go  = 1'b1;
                        state_in = S_SCAN;
                     end else begin
                        rec_go = 1'b1;
                     end
                  end
                  cdrc_pkg::OP_ROUND: begin
                     // A zero requested rate counts as one hertz.
                     div_go   = 1'b1;
                     div_a    = in_prate;
                     div_b    = (in_rate == '0) ? {{(W-1){1'b0}}, 1'b1} : in_rate;
                     state_in = S_DIV;
                  end
                  cdrc_pkg::OP_SET: begin
                     if (in_rate == '0) begin
                        fin     = 1'b1;
                        fin_bad = 1'b1;
                     end else begin
                        div_go   = 1'b1;
                        div_a    = in_prate;
                        div_b    = in_rate;
                        state_in = S_DIV;
                     end
                  end
                  cdrc_pkg::OP_SAVE: begin
                     saved_in = fv;
                     fin      = 1'b1;
                  end
                  cdrc_pkg::OP_RESTORE: begin
                     divr_in = rst_reg;
                     fin     = 1'b1;
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_res.done) begin
               case (op_ff)
                  cdrc_pkg::OP_RECALC: begin
                     fin      = 1'b1;
                     fin_rate = div_res.quot;
                     fin_div  = dv_ff;
                  end
                  cdrc_pkg::OP_ROUND: begin
                     if (second_ff) begin
                        fin      = 1'b1;
                        fin_rate = div_res.quot;
                        fin_div  = dv_ff;
                     end else if (mode_ff == cdrc_pkg::MODE_TABLE) begin
                        scan_go  = 1'b1;
                        state_in = S_SCAN;
                     end else begin
                        rnd_go = 1'b1;
                     end
                  end
                  cdrc_pkg::OP_SET: begin
                     if (mode_ff == cdrc_pkg::MODE_TABLE) begin
                        scan_go  = 1'b1;
                        state_in = S_SCAN;
                     end else begin
                        set_fin = 1'b1;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (scan_res.done) begin
               case (op_ff)
                  cdrc_pkg::OP_RECALC: rec_go   = 1'b1;
                  cdrc_pkg::OP_ROUND:  rnd_go   = 1'b1;
                  cdrc_pkg::OP_SET:    set_fin  = 1'b1;
                  default:             state_in = S_IDLE;
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Recalc: a zero divisor passes the parent rate straight through.
      if (rec_go) begin
         dv_in = rec_dv;
         if (rec_dv == '0) begin
            fin      = 1'b1;
            fin_rate = cur_prate;
            fin_zero = 1'b1;
         end else begin
            div_go   = 1'b1;
            div_a    = cur_prate;
            div_b    = rec_dv;
            state_in = S_DIV;
         end
      end

      // Round: divide the parent rate by the clamped divisor.
      if (rnd_go) begin
         dv_in     = rnd_dc;
         div_go    = 1'b1;
         div_a     = prate_ff;
         div_b     = rnd_dc;
         second_in = 1'b1;
         state_in  = S_DIV;
      end

      // Set: write the encoded field.
      if (set_fin) begin
         divr_in = set_reg;
         fin     = 1'b1;
         fin_div = div_res.quot;
      end

      if (fin) begin
         strobe_in   = 1'b1;
         res_rate_in = fin_rate;
         res_div_in  = fin_div;
         res_bad_in  = fin_bad;
         res_zero_in = fin_zero;
         state_in    = S_IDLE;
      end
   end

   cdrc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (div_a),
      .divisor  (div_b),
      .res      (div_res)
   );

   cdrc_scan #(
      .TAB_USED (TAB_USED)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (scan_go),
      .key_val  (fv),
      .key_div  (div_res.quot),
      .entries  (tab_entries),
      .res      (scan_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= cdrc_pkg::MODE_LINEAR;
         shift_ff  <= '0;
         width_ff  <= {{(WW-1){1'b0}}, 1'b1};
         hiword_ff <= 1'b0;
         pair_ff   <= '0;
         divr_ff   <= '0;
         saved_ff  <= '0;
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         shift_ff  <= shift_in;
         width_ff  <= width_in;
         hiword_ff <= hiword_in;
         pair_ff   <= pair_in;
         divr_ff   <= divr_in;
         saved_ff  <= saved_in;
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      prate_ff    <= prate_in;
      dv_ff       <= dv_in;
      second_ff   <= second_in;
      res_rate_ff <= res_rate_in;
      res_div_ff  <= res_div_in;
      res_bad_ff  <= res_bad_in;
      res_zero_ff <= res_zero_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_result_rate    = res_rate_ff;
   assign rsp_divisor        = res_div_ff;
   assign rsp_register_value = divr_ff;
   assign rsp_bad_request    = res_bad_ff;
   assign rsp_zero_divisor   = res_zero_ff;

`ifndef ASSERT_OFF
   // A result always leaves the block idle and ready for the next start.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // The divider only finishes while the sequencer waits on it.
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide state");

   // The table walk only finishes while the sequencer waits on it.
   a_scan_owner: assert property (@(posedge clock) disable iff (reset)
      scan_res.done |-> (state_ff == S_SCAN))
      else $error("table walk finished outside the scan state");

   // A set with a zero rate is refused on the next cycle.
   a_bad_set: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == cdrc_pkg::OP_SET) && (in_rate == '0))
      |=> (rsp_strobe && rsp_bad_request))
      else $error("zero-rate set not flagged");

   // A refused request and a zero divisor never come together.
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_bad_request && rsp_zero_divisor))
      else $error("bad request and zero divisor both set");
`endif

endmodule

// ===== rtl/cdrc_div.sv =====
module cdrc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [cdrc_pkg::RATE_W-1:0]  dividend,
   input  logic [cdrc_pkg::RATE_W-1:0]  divisor,
   output cdrc_pkg::div_res_type        res
);

   localparam int W  = cdrc_pkg::RATE_W;
   localparam int CW = cdrc_pkg::CNT_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [CW-1:0] low_one_ff, low_one_in;
   logic [CW-1:0] low_zero_ff, low_zero_in;
   logic [W:0]    shifted;
   logic [W+1:0]  diff;
   logic          qbit;
   logic          rem_nz;

   // One restoring step per cycle: shift in the next dividend bit and try to subtract.
   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      dsr_in      = dsr_ff;
      low_one_in  = low_one_ff;
      low_zero_in = low_zero_ff;
      shifted     = {rem_ff, quo_ff[W-1]};
      diff        = {1'b0, shifted} - {2'b00, dsr_ff};
      qbit        = ~diff[W+1];
      if (start) begin
         busy_in     = 1'b1;
         cnt_in      = '1;
         rem_in      = '0;
         quo_in      = dividend;
         dsr_in      = divisor;
         low_one_in  = '0;
         low_zero_in = '0;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[W-1:0] : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], qbit};
         // Bits come out from the top down, so the last hit is the lowest one.
         if (qbit) begin
            low_one_in = cnt_ff;
         end else begin
            low_zero_in = cnt_ff;
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dsr_ff      <= dsr_in;
      low_one_ff  <= low_one_in;
      low_zero_ff <= low_zero_in;
   end

   // Ceiling quotient; adding one turns the lowest zero of the quotient into its lowest one.
   assign rem_nz      = (rem_ff != '0);
   assign res.done    = done_ff;
   assign res.quot    = quo_ff + {{(W-1){1'b0}}, rem_nz};
   assign res.low_bit = rem_nz ? low_zero_ff : low_one_ff;

endmodule

// ===== rtl/cdrc_scan.sv =====
module cdrc_scan #(
   parameter int TAB_USED = cdrc_pkg::TAB_SLOTS
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  start,
   input  logic [cdrc_pkg::FIELD_W-1:0]                          key_val,
   input  logic [cdrc_pkg::RATE_W-1:0]                           key_div,
   input  logic [cdrc_pkg::TAB_SLOTS-1:0][cdrc_pkg::RATE_W-1:0]  entries,
   output cdrc_pkg::scan_res_type                                res
);

   localparam int IW = cdrc_pkg::TAB_IDX_W;
   localparam int DW = cdrc_pkg::TAB_DIV_W;
   localparam int VW = cdrc_pkg::TAB_VAL_W;
   localparam int UW = cdrc_pkg::UP_W;
   localparam int RW = cdrc_pkg::RATE_W;
   localparam int FW = cdrc_pkg::FIELD_W;
   localparam logic [IW-1:0] LAST = IW'(TAB_USED - 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [FW-1:0] kval_ff, kval_in;
   logic [RW-1:0] kdiv_ff, kdiv_in;
   logic          val_hit_ff, val_hit_in;
   logic [DW-1:0] val_div_ff, val_div_in;
   logic [DW-1:0] max_ff, max_in;
   logic [UW-1:0] min_ff, min_in;
   logic          div_hit_ff, div_hit_in;
   logic [VW-1:0] div_val_ff, div_val_in;
   logic [DW-1:0] t_div;
   logic [VW-1:0] t_val;

   assign t_div = entries[idx_ff][DW-1:0];
   assign t_val = entries[idx_ff][DW+VW-1:DW];

   // One table entry per cycle; a zero divisor or the last slot ends the walk.
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      idx_in     = idx_ff;
      kval_in    = kval_ff;
      kdiv_in    = kdiv_ff;
      val_hit_in = val_hit_ff;
      val_div_in = val_div_ff;
      max_in     = max_ff;
      min_in     = min_ff;
      div_hit_in = div_hit_ff;
      div_val_in = div_val_ff;
      if (start) begin
         busy_in    = 1'b1;
         idx_in     = '0;
         kval_in    = key_val;
         kdiv_in    = key_div;
         val_hit_in = 1'b0;
         val_div_in = '0;
         max_in     = '0;
         min_in     = cdrc_pkg::UP_LIMIT;
         div_hit_in = 1'b0;
         div_val_in = '0;
      end else if (busy_ff) begin
         if (t_div == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            // First entry whose value field matches the key.
            if (!val_hit_ff && ({{(FW-VW){1'b0}}, t_val} == kval_ff)) begin
               val_hit_in = 1'b1;
               val_div_in = t_div;
            end
            if (t_div > max_ff) begin
               max_in = t_div;
            end
            // Smallest divisor at or above the key.
            if (({{(RW-DW){1'b0}}, t_div} >= kdiv_ff) &&
                ({{(UW-DW){1'b0}}, t_div} < min_ff)) begin
               min_in = {{(UW-DW){1'b0}}, t_div};
            end
            // First entry whose divisor matches the key.
            if (!div_hit_ff && ({{(RW-DW){1'b0}}, t_div} == kdiv_ff)) begin
               div_hit_in = 1'b1;
               div_val_in = t_val;
            end
            if (idx_ff == LAST) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      kval_ff    <= kval_in;
      kdiv_ff    <= kdiv_in;
      val_hit_ff <= val_hit_in;
      val_div_ff <= val_div_in;
      max_ff     <= max_in;
      min_ff     <= min_in;
      div_hit_ff <= div_hit_in;
      div_val_ff <= div_val_in;
   end

   assign res.done    = done_ff;
   assign res.val_div = val_hit_ff ? val_div_ff : '0;
   assign res.max_div = max_ff;
   assign res.min_ge  = min_ff;
   assign res.div_val = div_hit_ff ? div_val_ff : '0;

endmodule

// ===== dv/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cdrc_pkg::*;

   // Opcodes past the defined set; the block must leave its state alone.
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   localparam int unsigned LIMIT_CYCLES   = 1_500_000;
   localparam int          PHASES         = 12;
   localparam int          ITEMS_PER_PHASE = 125;
   localparam int          TAIL_CYCLES    = 80;

   // One result of the block, field by field.
   typedef struct packed {
      logic [RATE_W-1:0] rate;
      logic [RATE_W-1:0] divisor;
      logic [RATE_W-1:0] ctrl;
      logic              bad;
      logic              zero;
   } calc_result_t;

   // One line of the directed script: a register write or an item.
   typedef struct packed {
      logic         is_csr;
      csr_idx_type  csr_sel;
      logic [63:0]  wdata;
      logic [2:0]   op;
      logic [31:0]  prate;
      logic [31:0]  rrate;
      logic         typed;
      calc_result_t want;
   } script_row_t;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [2:0]            req_opcode;
   logic [RATE_W-1:0]     req_parent_rate;
   logic [RATE_W-1:0]     req_requested_rate;
   logic                  rsp_strobe;
   logic [RATE_W-1:0]     rsp_result_rate;
   logic [RATE_W-1:0]     rsp_divisor;
   logic [RATE_W-1:0]     rsp_register_value;
   logic                  rsp_bad_request;
   logic                  rsp_zero_divisor;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Predicted configuration and state of the divider.
   div_mode_type cfg_mode;
   logic [4:0]   cfg_shift;
   logic [4:0]   cfg_width;
   logic         cfg_hiword;
   logic [63:0]  cfg_table [PAIRS];
   logic [31:0]  ctrl_reg;
   logic [15:0]  kept_field;

   calc_result_t outstanding_calcs [$];
   script_row_t  script [$];
   int unsigned  mismatch_count;
   int unsigned  cycle_count;

   clock_divider_rate_calc uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_parent_rate    (req_parent_rate),
      .req_requested_rate (req_requested_rate),
      .rsp_strobe         (rsp_strobe),
      .rsp_result_rate    (rsp_result_rate),
      .rsp_divisor        (rsp_divisor),
      .rsp_register_value (rsp_register_value),
      .rsp_bad_request    (rsp_bad_request),
      .rsp_zero_divisor   (rsp_zero_divisor),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Field mask; widths above sixteen act as sixteen.
   function automatic logic [15:0] field_mask();
      logic [4:0]  w;
      logic [16:0] full;
      w = (cfg_width > 5'd16) ? 5'd16 : cfg_width;
      full = (17'd1 << w) - 17'd1;
      return full[15:0];
   endfunction

   // Move a value to the field position; bits past bit 31 are dropped.
   function automatic logic [31:0] place(logic [15:0] v, int sh);
      logic [63:0] wide;
      wide = {48'd0, v} << sh;
      return wide[31:0];
   endfunction

   function automatic logic [15:0] field_value();
      logic [31:0] s;
      s = ctrl_reg >> cfg_shift;
      return s[15:0] & field_mask();
   endfunction

   function automatic logic [15:0] entry_div(int i);
      return cfg_table[i / 2][(i % 2) * 32 +: 16];
   endfunction

   function automatic logic [7:0] entry_val(int i);
      return cfg_table[i / 2][(i % 2) * 32 + 16 +: 8];
   endfunction

   // Number of table entries in use: the first zero divisor ends the table.
   function automatic int table_len();
      int n;
      n = 0;
      while (n < TAB_SLOTS && entry_div(n) != 16'd0) n++;
      return n;
   endfunction

   function automatic logic [31:0] pow2_capped(logic [15:0] e);
      return 32'd1 << ((e > 16'd31) ? 5'd31 : e[4:0]);
   endfunction

   function automatic logic [31:0] ceil_quot(logic [31:0] a, logic [31:0] d);
      return a / d + (((a % d) != 32'd0) ? 32'd1 : 32'd0);
   endfunction

   // Field value to divisor; a table miss gives zero.
   function automatic logic [31:0] decode_field(logic [15:0] v);
      logic [31:0] d;
      int          i;
      d = 32'd0;
      case (cfg_mode)
         MODE_ONE_BASED: d = {16'd0, v};
         MODE_POW2:      d = pow2_capped(v);
         MODE_TABLE: begin
            for (i = table_len() - 1; i >= 0; i--) begin
               if ({8'd0, entry_val(i)} == v) d = {16'd0, entry_div(i)};
            end
         end
         default:        d = {16'd0, v} + 32'd1;
      endcase
      return d;
   endfunction

   function automatic logic [31:0] max_divisor();
      logic [31:0] mx;
      int          i;
      mx = 32'd0;
      case (cfg_mode)
         MODE_ONE_BASED: mx = {16'd0, field_mask()};
         MODE_POW2:      mx = pow2_capped(field_mask());
         MODE_TABLE: begin
            for (i = 0; i < table_len(); i++) begin
               if ({16'd0, entry_div(i)} > mx) mx = {16'd0, entry_div(i)};
            end
         end
         default:        mx = {16'd0, field_mask()} + 32'd1;
      endcase
      return mx;
   endfunction

   // Divisor to field value; a table miss gives zero.
   function automatic logic [31:0] encode_divisor(logic [31:0] d);
      logic [31:0] v;
      int          i;
      v = 32'd0;
      case (cfg_mode)
         MODE_ONE_BASED: v = d;
         MODE_POW2: begin
            for (i = 31; i >= 0; i--) begin
               if (d[i]) v = i;
            end
         end
         MODE_TABLE: begin
            for (i = table_len() - 1; i >= 0; i--) begin
               if ({16'd0, entry_div(i)} == d) v = {24'd0, entry_val(i)};
            end
         end
         default:        v = d - 32'd1;
      endcase
      return v;
   endfunction

   // Works out the result of one item and advances the predicted state.
   function automatic calc_result_t calc_rate_op(logic [2:0] op, logic [31:0] prate,
                                                 logic [31:0] rrate);
      calc_result_t res;
      logic [15:0]  m;
      logic [31:0]  fm;
      logic [31:0]  d;
      logic [31:0]  mx;
      logic [31:0]  up;
      logic [31:0]  t;
      logic [31:0]  v;
      logic [31:0]  w;
      int           i;
      bit           hit;
      res = '0;
      m = field_mask();
      fm = place(m, cfg_shift);
      case (op)
         OP_RECALC: begin
            res.divisor = decode_field(field_value());
            if (res.divisor == 32'd0) begin
               res.rate = prate;
               res.zero = 1'b1;
            end else begin
               res.rate = ceil_quot(prate, res.divisor);
            end
         end
         OP_ROUND: begin
            d = ceil_quot(prate, (rrate == 32'd0) ? 32'd1 : rrate);
            mx = max_divisor();
            // In table mode take the exact divisor or the next larger one.
            if (cfg_mode == MODE_TABLE) begin
               up = 32'h7FFF_FFFF;
               hit = 1'b0;
               for (i = 0; i < table_len() && !hit; i++) begin
                  t = {16'd0, entry_div(i)};
                  if (t == d) begin
                     up = t;
                     hit = 1'b1;
                  end else if (t > d && t < up) begin
                     up = t;
                  end
               end
               d = up;
            end
            if (d > mx) d = mx;
            if (d == 32'd0) d = 32'd1;
            res.divisor = d;
            res.rate = ceil_quot(prate, d);
         end
         OP_SET: begin
            if (rrate == 32'd0) begin
               res.bad = 1'b1;
            end else begin
               res.divisor = ceil_quot(prate, rrate);
               v = encode_divisor(res.divisor);
               if (v > {16'd0, m}) v = {16'd0, m};
               if (cfg_hiword) w = place(m, int'(cfg_shift) + 16);
               else w = ctrl_reg & ~fm;
               ctrl_reg = w | place(v[15:0], cfg_shift);
            end
         end
         OP_SAVE: kept_field = field_value();
         OP_RESTORE: ctrl_reg = (ctrl_reg & ~fm) | place(kept_field, cfg_shift);
         default: ;
      endcase
      res.ctrl = ctrl_reg;
      return res;
   endfunction

   function automatic void add_csr(csr_idx_type idx, logic [63:0] data);
      script_row_t row;
      row = '0;
      row.is_csr = 1'b1;
      row.csr_sel = idx;
      row.wdata = data;
      script.push_back(row);
   endfunction

   function automatic void add_item(logic [2:0] op, logic [31:0] prate, logic [31:0] rrate);
      script_row_t row;
      row = '0;
      row.op = op;
      row.prate = prate;
      row.rrate = rrate;
      script.push_back(row);
   endfunction

   function automatic void add_typed(logic [2:0] op, logic [31:0] prate, logic [31:0] rrate,
                                     logic [31:0] rate, logic [31:0] dv, logic [31:0] ctrl,
                                     logic bad, logic zero);
      script_row_t row;
      row = '0;
      row.op = op;
      row.prate = prate;
      row.rrate = rrate;
      row.typed = 1'b1;
      row.want = '{rate: rate, divisor: dv, ctrl: ctrl, bad: bad, zero: zero};
      script.push_back(row);
   endfunction

   function automatic logic [31:0] pick_parent();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return $urandom_range(1, 5000);
         4:       return 32'd1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // Requested rates mostly sit at a small or table divisor of the parent.
   function automatic logic [31:0] pick_request(logic [31:0] prate);
      logic [31:0] k;
      int          n;
      n = table_len();
      k = 32'd1;
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return $urandom;
         2:       return 32'hFFFF_FFFF;
         3, 4:    k = (n > 0) ? {16'd0, entry_div($urandom_range(0, n - 1))} : 32'd3;
         5:       k = $urandom_range(1, 70000);
         default: k = $urandom_range(1, 40);
      endcase
      return prate / k + $urandom_range(0, 1);
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < 100) begin
         $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
      end
      mismatch_count++;
   endtask

   // One register transfer; the predicted configuration follows it.
   task automatic write_csr(csr_idx_type idx, logic [63:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_DIV_MODE:    cfg_mode = div_mode_type'(data[1:0]);
         CSR_FIELD_SHIFT: cfg_shift = data[4:0];
         CSR_FIELD_WIDTH: cfg_width = data[4:0];
         CSR_HIWORD_MASK: cfg_hiword = data[0];
         default:         cfg_table[idx - CSR_TABLE_0] = data;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Offer one item until the block takes it, then queue its expected result.
   task automatic send_calc(logic [2:0] op, logic [31:0] prate, logic [31:0] rrate,
                            logic typed, calc_result_t want);
      calc_result_t predicted;
      @(negedge clock);
      start = 1'b1;
      req_opcode = op;
      req_parent_rate = prate;
      req_requested_rate = rrate;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = calc_rate_op(op, prate, rrate);
      outstanding_calcs.push_back(typed ? want : predicted);
   endtask

   // Stop sending and wait until every expected result has come.
   task automatic settle();
      @(negedge clock);
      start = 1'b0;
      while (outstanding_calcs.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Compare each strobed result with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      calc_result_t want;
      if (!reset && rsp_strobe) begin
         if (outstanding_calcs.size() == 0) begin
            flag_mismatch("result with nothing pending, rate", rsp_result_rate, 32'd0);
         end else begin
            want = outstanding_calcs.pop_front();
            if (rsp_result_rate !== want.rate)
               flag_mismatch("result_rate", rsp_result_rate, want.rate);
            if (rsp_divisor !== want.divisor)
               flag_mismatch("divisor", rsp_divisor, want.divisor);
            if (rsp_register_value !== want.ctrl)
               flag_mismatch("register_value", rsp_register_value, want.ctrl);
            if (rsp_bad_request !== want.bad)
               flag_mismatch("bad_request", rsp_bad_request, want.bad);
            if (rsp_zero_divisor !== want.zero)
               flag_mismatch("zero_divisor", rsp_zero_divisor, want.zero);
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("clock_divider_rate_calc test failed");
      $finish;
   end

   initial begin
      logic [63:0]  junk;
      logic [63:0]  pairs [PAIRS];
      logic [31:0]  entry;
      logic [31:0]  prate;
      logic [31:0]  rrate;
      logic [2:0]   op;
      div_mode_type mode;
      logic [4:0]   sh;
      logic [4:0]   wd;
      logic         hw;
      bit           quiet;
      int           phase;
      int           n;
      int           i;
      int           len;
      int           gap;
      int           pick;

      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_RECALC;
      req_parent_rate = '0;
      req_requested_rate = '0;
      csr_valid = 1'b0;
      csr_index = CSR_DIV_MODE;
      csr_wdata = '0;
      mismatch_count = 0;
      cfg_mode = MODE_LINEAR;
      cfg_shift = 5'd0;
      cfg_width = 5'd1;
      cfg_hiword = 1'b0;
      for (i = 0; i < PAIRS; i++) cfg_table[i] = '0;
      ctrl_reg = '0;
      kept_field = '0;

      // Reset settings: linear divider, one-bit field at bit zero.
      add_typed(OP_RECALC, 32'd1000, 32'd0, 32'd1000, 32'd1, 32'd0, 1'b0, 1'b0);
      add_typed(OP_SET, 32'd1000, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0);
      add_typed(OP_ROUND, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'd2, 32'd0, 1'b0, 1'b0);
      add_typed(OP_SET, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd1, 1'b0, 1'b0);
      add_typed(OP_SAVE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 1'b0, 1'b0);
      // A zero parent wraps the linear code to all ones, then saturates.
      add_typed(OP_SET, 32'd0, 32'd5, 32'd0, 32'd0, 32'd1, 1'b0, 1'b0);
      add_typed(OP_SET, 32'd10, 32'd10, 32'd0, 32'd1, 32'd0, 1'b0, 1'b0);
      add_typed(OP_RESTORE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 1'b0, 1'b0);
      add_typed(OP_SPARE_LO, 32'd77, 32'd5, 32'd0, 32'd0, 32'd1, 1'b0, 1'b0);
      add_typed(OP_SPARE_HI, 32'd77, 32'd5, 32'd0, 32'd0, 32'd1, 1'b0, 1'b0);

      // One-based field of sixteen bits: saturation and a zero divisor.
      add_csr(CSR_DIV_MODE, {62'd0, MODE_ONE_BASED});
      add_csr(CSR_FIELD_WIDTH, 64'd16);
      add_item(OP_SET, 32'hFFFF_FFFF, 32'h0001_0000);
      add_item(OP_SET, 32'd0, 32'd1);
      add_typed(OP_RECALC, 32'd12345, 32'd0, 32'd12345, 32'd0, 32'd0, 1'b0, 1'b1);
      add_item(OP_SET, 32'd1000, 32'd1);
      add_item(OP_SAVE, 32'd0, 32'd0);

      // Power of two: exponent above 31 saturates; non-power divisor on set.
      add_csr(CSR_DIV_MODE, {62'd0, MODE_POW2});
      add_item(OP_RECALC, 32'hFFFF_FFFF, 32'd0);
      add_item(OP_ROUND, 32'hFFFF_FFFF, 32'd1);
      add_item(OP_SET, 32'd12, 32'd1);

      // Two-entry table ended by a zero divisor, field in the top nibble,
      // hiword writes. Entry three lies past the end and must be ignored.
      add_csr(CSR_TABLE_0, {8'h00, 8'd2, 16'd10, 8'hA5, 8'd5, 16'd3});
      add_csr(CSR_TABLE_1, {8'h3C, 8'd9, 16'd7, 8'hC3, 8'd0, 16'd0});
      add_csr(CSR_DIV_MODE, {62'd0, MODE_TABLE});
      add_csr(CSR_FIELD_SHIFT, 64'd28);
      add_csr(CSR_FIELD_WIDTH, 64'd4);
      add_csr(CSR_HIWORD_MASK, 64'd1);
      add_item(OP_SET, 32'd100, 32'd10);
      add_item(OP_RECALC, 32'd100, 32'd0);
      add_item(OP_SET, 32'd100, 32'd15);
      add_item(OP_RECALC, 32'd100, 32'd0);
      add_item(OP_ROUND, 32'd100, 32'd20);
      add_item(OP_ROUND, 32'd100, 32'd1);
      add_item(OP_RESTORE, 32'd0, 32'd0);

      // Empty table, then an empty one-based field: round falls back to one.
      add_csr(CSR_TABLE_0, 64'd0);
      add_item(OP_ROUND, 32'd500, 32'd7);
      add_csr(CSR_DIV_MODE, {62'd0, MODE_ONE_BASED});
      add_csr(CSR_FIELD_WIDTH, 64'd0);
      add_item(OP_ROUND, 32'd500, 32'd7);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed script.
      foreach (script[k]) begin
         if (script[k].is_csr) begin
            settle();
            write_csr(script[k].csr_sel, script[k].wdata);
         end else begin
            send_calc(script[k].op, script[k].prate, script[k].rrate,
                      script[k].typed, script[k].want);
         end
      end
      settle();

      // Random phases, each under its own divider setup.
      for (phase = 0; phase < PHASES; phase++) begin
         mode = (phase < 8) ? div_mode_type'(phase % 4) : div_mode_type'($urandom_range(0, 3));
         case (phase)
            1, 6:    sh = 5'd31;
            2, 5:    sh = 5'd0;
            default: sh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(0, 16);
         endcase
         case (phase)
            0:       wd = 5'd16;
            3:       wd = 5'd0;
            4:       wd = 5'd31;
            7:       wd = 5'd1;
            default: wd = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(1, 16);
         endcase
         hw = (phase < 2) ? phase[0] : $urandom_range(0, 1);
         len = (phase == 3) ? 0 : $urandom_range(0, TAB_SLOTS);
         for (i = 0; i < TAB_SLOTS; i++) begin
            entry = $urandom;
            if (i < len) begin
               pick = $urandom_range(0, 9);
               entry[15:0] = (pick == 0) ? 16'hFFFF :
                             (pick == 1) ? $urandom_range(1, 16'hFFFF) : $urandom_range(1, 24);
               entry[23:16] = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
            end else if (i == len) begin
               entry[15:0] = 16'd0;
            end
            pairs[i / 2][(i % 2) * 32 +: 32] = entry;
         end

         settle();
         junk = {$urandom, $urandom};
         write_csr(CSR_DIV_MODE, {junk[63:2], mode});
         write_csr(CSR_FIELD_SHIFT, {junk[63:5], sh});
         write_csr(CSR_FIELD_WIDTH, {junk[63:5], wd});
         write_csr(CSR_HIWORD_MASK, {junk[63:1], hw});
         write_csr(CSR_TABLE_0, pairs[0]);
         write_csr(CSR_TABLE_1, pairs[1]);
         write_csr(CSR_TABLE_2, pairs[2]);
         write_csr(CSR_TABLE_3, pairs[3]);

         quiet = (phase % 4 == 2);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Halfway through, hold off until the block has drained.
            if (n == ITEMS_PER_PHASE / 2) settle();
            pick = $urandom_range(0, 99);
            if (pick < 24) op = OP_RECALC;
            else if (pick < 48) op = OP_ROUND;
            else if (pick < 74) op = OP_SET;
            else if (pick < 84) op = OP_SAVE;
            else if (pick < 95) op = OP_RESTORE;
            else op = $urandom_range(OP_SPARE_LO, OP_SPARE_HI);
            prate = pick_parent();
            rrate = pick_request(prate);
            send_calc(op, prate, rrate, 1'b0, '0);

            // Mostly back to back or short gaps, now and then a long one.
            pick = $urandom_range(0, 99);
            if (quiet || pick < 55) gap = 0;
            else if (pick < 90) gap = $urandom_range(1, 4);
            else gap = $urandom_range(20, 90);
            if (gap > 0) begin
               @(negedge clock);
               start = 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (outstanding_calcs.size() != 0)
         flag_mismatch("results never arrived, count", outstanding_calcs.size(), 32'd0);
      if (mismatch_count == 0) begin
         $display("clock_divider_rate_calc test passed");
      end else begin
         $display("clock_divider_rate_calc test failed");
      end
      $finish;
   end

endmodule
